// ===== hw/rtl/ttd_pkg.sv =====
// ============================================================================
// ttd_pkg
// Shared types and constants for the touch tap and drag recognizer: event and
// result codes, register indexes, and the structs passed between its modules.
// ============================================================================
package ttd_pkg;

    localparam int CoordW = 15;
    localparam int StepW  = 16;
    localparam int AddrW  = 5;
    localparam int DataW  = 32;

    // Event kinds carried in the input tuser field.
    typedef enum logic [1:0] {
        MODE_PRESS   = 2'd0,
        MODE_MOVE    = 2'd1,
        MODE_RELEASE = 2'd2,
        MODE_OTHER   = 2'd3
    } t_mode;

    // Gesture codes carried in the output tuser field.
    typedef enum logic [1:0] {
        GEST_NONE    = 2'd0,
        GEST_DRAGGED = 2'd1,
        GEST_TOUCHED = 2'd2
    } t_gesture;

    // Register indexes; byte address is four times the index.
    typedef enum logic [2:0] {
        REG_REGION_LEFT   = 3'd0,
        REG_REGION_TOP    = 3'd1,
        REG_REGION_WIDTH  = 3'd2,
        REG_REGION_HEIGHT = 3'd3,
        REG_DRAG_THRESH   = 3'd4,
        REG_VERT_EN       = 3'd5,
        REG_HORIZ_EN      = 3'd6,
        REG_MULTI_AXIS_EN = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [CoordW-1:0] region_left;
        logic [CoordW-1:0] region_top;
        logic [CoordW-1:0] region_width;
        logic [CoordW-1:0] region_height;
        logic [CoordW-1:0] drag_threshold;
        logic              vertical_enable;
        logic              horizontal_enable;
        logic              multi_axis_enable;
    } t_cfg;

    typedef struct packed {
        t_mode             mode;
        logic [CoordW-1:0] point_x;
        logic [CoordW-1:0] point_y;
    } t_event;

    typedef struct packed {
        t_gesture                 gesture;
        logic signed [StepW-1:0]  drag_dx;
        logic signed [StepW-1:0]  drag_dy;
    } t_result;

    // Stage handshake between the input register and the rest of the block.
    typedef struct packed {
        logic   valid;
        t_event evt;
    } t_in_stage;

endpackage

// ===== hw/rtl/touch_tap_drag_recognizer.sv =====
// An accepted event passes the input register, then its result is loaded into the result register.
// Throughput: one event per cycle while the output is not stalled, set by the input
// register feeding a single pass of compare and subtract logic into the result register.
// Every event yields exactly one result transaction.
// Reset (synchronous, active low) disarms, clears both locks and the stored
// point, empties both registers and loads the register defaults.
// ============================================================================
// touch_tap_drag_recognizer
// Top level: stream input of touch events, stream output of gesture results,
// APB configuration port.
// ============================================================================
module touch_tap_drag_recognizer (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [31:0]                s_tdata,   // [14:0] point_x, [29:15] point_y
    input  logic [1:0]                 s_tuser,   // [1:0] mode
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,   // [15:0] drag_dx, [31:16] drag_dy
    output logic [1:0]                 m_tuser,   // [1:0] gesture
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ttd_pkg::AddrW-1:0]  paddr,
    input  logic [ttd_pkg::DataW-1:0]  pwdata,
    output logic [ttd_pkg::DataW-1:0]  prdata,
    output logic                       pready
);
    import ttd_pkg::*;

    t_cfg      w_cfg;
    t_event    w_in_evt;
    t_in_stage w_stage;
    t_result   w_result;
    t_result   w_out;
    logic      w_out_ready;
    logic      w_fire;

    // The result register can load when empty or when its transaction completes.
    assign w_out_ready = !m_tvalid || m_tready;
    assign s_tready    = !w_stage.valid || w_out_ready;
    assign w_fire      = w_stage.valid && w_out_ready;

    assign w_in_evt.mode    = t_mode'(s_tuser);
    assign w_in_evt.point_x = s_tdata[CoordW-1:0];
    assign w_in_evt.point_y = s_tdata[2*CoordW-1:CoordW];

    ttd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ttd_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (s_tready),
        .i_valid (s_tvalid),
        .i_evt   (w_in_evt),
        .o_stage (w_stage)
    );

    ttd_gesture u_gesture (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_cfg    (w_cfg),
        .i_evt    (w_stage.evt),
        .o_result (w_result)
    );

    ttd_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_out_ready),
        .i_valid  (w_stage.valid),
        .i_result (w_result),
        .o_valid  (m_tvalid),
        .o_result (w_out)
    );

    assign m_tuser = w_out.gesture;
    assign m_tdata = {w_out.drag_dy, w_out.drag_dx};

endmodule

// ===== hw/rtl/ttd_cfg.sv =====
// ============================================================================
// ttd_cfg
// APB register file holding the sensitive rectangle, the drag threshold and
// the axis enables. Writes complete in the access phase; pready is always high.
// ============================================================================
module ttd_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ttd_pkg::AddrW-1:0]  paddr,
    input  logic [ttd_pkg::DataW-1:0]  pwdata,
    output logic [ttd_pkg::DataW-1:0]  prdata,
    output logic                       pready,
    output ttd_pkg::t_cfg              o_cfg
);
    import ttd_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[AddrW-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    // Register writes; each field keeps only its own low bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.region_left       <= '0;
            r_cfg.region_top        <= '0;
            r_cfg.region_width      <= '1;
            r_cfg.region_height     <= '1;
            r_cfg.drag_threshold    <= '0;
            r_cfg.vertical_enable   <= 1'b1;
            r_cfg.horizontal_enable <= 1'b1;
            r_cfg.multi_axis_enable <= 1'b0;
        end else if (w_wr) begin
            case (w_idx)
                REG_REGION_LEFT:   r_cfg.region_left       <= pwdata[CoordW-1:0];
                REG_REGION_TOP:    r_cfg.region_top        <= pwdata[CoordW-1:0];
                REG_REGION_WIDTH:  r_cfg.region_width      <= pwdata[CoordW-1:0];
                REG_REGION_HEIGHT: r_cfg.region_height     <= pwdata[CoordW-1:0];
                REG_DRAG_THRESH:   r_cfg.drag_threshold    <= pwdata[CoordW-1:0];
                REG_VERT_EN:       r_cfg.vertical_enable   <= pwdata[0];
                REG_HORIZ_EN:      r_cfg.horizontal_enable <= pwdata[0];
                REG_MULTI_AXIS_EN: r_cfg.multi_axis_enable <= pwdata[0];
                default:           r_cfg <= r_cfg;
            endcase
        end
    end

    // Read-back of the addressed register, zero extended.
    always_comb begin
        case (w_idx)
            REG_REGION_LEFT:   prdata = DataW'(r_cfg.region_left);
            REG_REGION_TOP:    prdata = DataW'(r_cfg.region_top);
            REG_REGION_WIDTH:  prdata = DataW'(r_cfg.region_width);
            REG_REGION_HEIGHT: prdata = DataW'(r_cfg.region_height);
            REG_DRAG_THRESH:   prdata = DataW'(r_cfg.drag_threshold);
            REG_VERT_EN:       prdata = DataW'(r_cfg.vertical_enable);
            REG_HORIZ_EN:      prdata = DataW'(r_cfg.horizontal_enable);
            REG_MULTI_AXIS_EN: prdata = DataW'(r_cfg.multi_axis_enable);
            default:           prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/ttd_in_stage.sv =====
// ============================================================================
// ttd_in_stage
// Input register: captures one touch event per accepted transaction and holds
// it until the gesture logic consumes it.
// ============================================================================
module ttd_in_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_load,
    input  logic                        i_valid,
    input  ttd_pkg::t_event             i_evt,
    output ttd_pkg::t_in_stage          o_stage
);
    import ttd_pkg::*;

    logic   r_valid;
    t_event r_evt;

    // Valid flag follows the upstream side whenever the stage may load.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    // Event payload is captured only on an accepted transaction.
    always_ff @(posedge i_clk) begin
        if (i_load && i_valid) begin
            r_evt <= i_evt;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.evt   = r_evt;

endmodule

// ===== hw/rtl/ttd_gesture.sv =====
// ============================================================================
// ttd_gesture
// Gesture state and single-pass decision logic: region test on press, step
// and axis locking on move, tap detection on release.
// ============================================================================
module ttd_gesture (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  ttd_pkg::t_cfg     i_cfg,
    input  ttd_pkg::t_event   i_evt,
    output ttd_pkg::t_result  o_result
);
    import ttd_pkg::*;

    logic              r_armed;
    logic              r_vlock;
    logic              r_hlock;
    logic [CoordW-1:0] r_prev_x;
    logic [CoordW-1:0] r_prev_y;

    logic              n_armed;
    logic              n_vlock;
    logic              n_hlock;
    logic              w_store_pt;

    logic              w_in_x;
    logic              w_in_y;
    logic [CoordW:0]   w_x_end;
    logic [CoordW:0]   w_y_end;
    logic signed [StepW-1:0] w_dx;
    logic signed [StepW-1:0] w_dy;
    logic [StepW-1:0]  w_dx_abs;
    logic [StepW-1:0]  w_dy_abs;
    logic [CoordW-1:0] w_ax;
    logic [CoordW-1:0] w_ay;
    logic              w_lock_v;
    logic              w_lock_h;

    // Rectangle test; the end bound is one bit wider so it cannot wrap.
    assign w_x_end = {1'b0, i_cfg.region_left} + {1'b0, i_cfg.region_width};
    assign w_y_end = {1'b0, i_cfg.region_top}  + {1'b0, i_cfg.region_height};
    assign w_in_x  = (i_evt.point_x >= i_cfg.region_left) && ({1'b0, i_evt.point_x} < w_x_end);
    assign w_in_y  = (i_evt.point_y >= i_cfg.region_top)  && ({1'b0, i_evt.point_y} < w_y_end);

    // Step from the stored point and its magnitude past the threshold.
    assign w_dx     = $signed({1'b0, i_evt.point_x}) - $signed({1'b0, r_prev_x});
    assign w_dy     = $signed({1'b0, i_evt.point_y}) - $signed({1'b0, r_prev_y});
    assign w_dx_abs = w_dx[StepW-1] ? StepW'(-w_dx) : StepW'(w_dx);
    assign w_dy_abs = w_dy[StepW-1] ? StepW'(-w_dy) : StepW'(w_dy);
    assign w_ax     = (w_dx_abs[CoordW-1:0] > i_cfg.drag_threshold) ? w_dx_abs[CoordW-1:0] : '0;
    assign w_ay     = (w_dy_abs[CoordW-1:0] > i_cfg.drag_threshold) ? w_dy_abs[CoordW-1:0] : '0;

    // Lock choice for a move while no axis is locked yet.
    always_comb begin
        w_lock_v = 1'b0;
        w_lock_h = 1'b0;
        if (i_cfg.multi_axis_enable) begin
            w_lock_v = i_cfg.vertical_enable && (w_ay != '0);
            w_lock_h = i_cfg.horizontal_enable && (w_ax != '0);
        end else if (i_cfg.vertical_enable && i_cfg.horizontal_enable) begin
            w_lock_v = (w_ay > w_ax);
            w_lock_h = !(w_ay > w_ax) && (w_ax != '0);
        end else if (i_cfg.vertical_enable) begin
            w_lock_v = (w_ay != '0);
        end else if (i_cfg.horizontal_enable) begin
            w_lock_h = (w_ax != '0);
        end
    end

    // Next state and result for the event in the input register.
    always_comb begin
        n_armed    = r_armed;
        n_vlock    = r_vlock;
        n_hlock    = r_hlock;
        w_store_pt = 1'b0;
        o_result.gesture = GEST_NONE;
        o_result.drag_dx = '0;
        o_result.drag_dy = '0;
        case (i_evt.mode)
            MODE_PRESS: begin
                if (w_in_x && w_in_y) begin
                    n_armed    = 1'b1;
                    n_vlock    = 1'b0;
                    n_hlock    = 1'b0;
                    w_store_pt = 1'b1;
                end
            end
            MODE_MOVE: begin
                if (r_armed) begin
                    w_store_pt = 1'b1;
                    if (!r_vlock && !r_hlock) begin
                        n_vlock = w_lock_v;
                        n_hlock = w_lock_h;
                    end
                    if (n_vlock || n_hlock) begin
                        o_result.gesture = GEST_DRAGGED;
                        o_result.drag_dx = n_hlock ? w_dx : '0;
                        o_result.drag_dy = n_vlock ? w_dy : '0;
                    end
                end
            end
            MODE_RELEASE: begin
                if (r_armed) begin
                    n_armed = 1'b0;
                    if (!r_vlock && !r_hlock) begin
                        o_result.gesture = GEST_TOUCHED;
                    end
                end
            end
            default: begin
                n_armed = r_armed;
            end
        endcase
    end

    // State update when the event moves on to the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed  <= 1'b0;
            r_vlock  <= 1'b0;
            r_hlock  <= 1'b0;
            r_prev_x <= '0;
            r_prev_y <= '0;
        end else if (i_fire) begin
            r_armed <= n_armed;
            r_vlock <= n_vlock;
            r_hlock <= n_hlock;
            if (w_store_pt) begin
                r_prev_x <= i_evt.point_x;
                r_prev_y <= i_evt.point_y;
            end
        end
    end

endmodule

// ===== hw/rtl/ttd_out_stage.sv =====
// ============================================================================
// ttd_out_stage
// Result register: holds one gesture result until the downstream side takes
// the transaction.
// ============================================================================
module ttd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_valid,
    input  ttd_pkg::t_result  i_result,
    output logic              o_valid,
    output ttd_pkg::t_result  o_result
);
    import ttd_pkg::*;

    logic    r_valid;
    t_result r_result;

    // Valid flag reloads whenever the register is empty or being drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_valid;
        end
    end

    // Result payload is captured with each new event.
    always_ff @(posedge i_clk) begin
        if (i_load && i_valid) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== hw/rtl/ttd_checker.sv =====
// ============================================================================
// ttd_checker
// Port-level checks for the touch tap and drag recognizer, bound to the top.
// ============================================================================
module ttd_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [31:0]                m_tdata,
    input logic [1:0]                 m_tuser,
    input logic                       pready
);
    import ttd_pkg::*;

    // A result never carries the unused gesture code.
    a_gesture_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tuser == GEST_NONE || m_tuser == GEST_DRAGGED ||
                      m_tuser == GEST_TOUCHED))
        else $error("gesture code out of range");

    // Steps are reported only with a drag.
    a_step_only_drag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser != GEST_DRAGGED) |-> (m_tdata == '0))
        else $error("nonzero step without a drag");

    // A stalled result transaction holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("output changed while stalled");

    // Reset empties the pipeline and the APB port stays ready.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!m_tvalid && pready))
        else $error("result pending after reset");

    // An event accepted with no result pending shows a result at the output.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready && !m_tvalid) |=> ##1 m_tvalid)
        else $error("result missing after accepted event");

endmodule

bind touch_tap_drag_recognizer ttd_checker u_ttd_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .pready   (pready)
);

// ===== tb/ttd_gesture_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// ttd_gesture_checker
// Watches the event, result and register channels of the touch tap and drag
// recognizer. Keeps its own copy of the registers and the gesture state,
// predicts the gesture for every accepted event and compares each accepted
// result transaction with the oldest prediction.
// ============================================================================
module ttd_gesture_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    input  logic                        i_s_tready,
    input  logic [31:0]                 i_s_tdata,   // [14:0] point_x, [29:15] point_y
    input  logic [1:0]                  i_s_tuser,   // [1:0] mode
    input  logic                        i_m_tvalid,
    input  logic                        i_m_tready,
    input  logic [31:0]                 i_m_tdata,   // [15:0] drag_dx, [31:16] drag_dy
    input  logic [1:0]                  i_m_tuser,   // [1:0] gesture
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [ttd_pkg::AddrW-1:0]   i_paddr,
    input  logic [ttd_pkg::DataW-1:0]   i_pwdata,
    input  logic                        i_pready,
    output int                          o_fail_count,
    output int                          o_pending,
    output int                          o_result_count,
    output int                          o_drag_count,
    output int                          o_touch_count
);
    import ttd_pkg::*;

    t_cfg    cfg;
    logic    armed;
    logic    vert_locked;
    logic    horiz_locked;
    int      prev_x;
    int      prev_y;
    t_result expected_gestures[$];

    // True when v lies in the half-open span [start, start + len).
    function automatic logic covers(input int unsigned v, input int unsigned start,
                                    input int unsigned len);
        return (v >= start) && (v < start + len);
    endfunction

    // Advances the gesture state by one event and returns the gesture it yields.
    function automatic t_result recognize_event(input t_event ev);
        t_result res;
        int      px;
        int      py;
        int      sx;
        int      sy;
        int      mx;
        int      my;
        int      thr;
        px  = ev.point_x;
        py  = ev.point_y;
        thr = cfg.drag_threshold;
        res.gesture = GEST_NONE;
        res.drag_dx = '0;
        res.drag_dy = '0;
        if (ev.mode == MODE_PRESS && covers(px, cfg.region_left, cfg.region_width)
            && covers(py, cfg.region_top, cfg.region_height)) begin
            armed        = 1'b1;
            vert_locked  = 1'b0;
            horiz_locked = 1'b0;
            prev_x       = px;
            prev_y       = py;
        end else if (armed && ev.mode == MODE_MOVE) begin
            sx = px - prev_x;
            sy = py - prev_y;
            mx = (sx < 0) ? -sx : sx;
            my = (sy < 0) ? -sy : sy;
            prev_x = px;
            prev_y = py;
            // A step only counts once it exceeds the threshold.
            if (mx <= thr) mx = 0;
            if (my <= thr) my = 0;

            // Locks are only taken while neither axis holds one.
            if (!vert_locked && !horiz_locked) begin
                if (cfg.multi_axis_enable) begin
                    if (cfg.vertical_enable && my > 0) vert_locked = 1'b1;
                    if (cfg.horizontal_enable && mx > 0) horiz_locked = 1'b1;
                end else if (cfg.vertical_enable && cfg.horizontal_enable) begin
                    // Larger step wins; a tie goes to horizontal.
                    if (my > mx) vert_locked = 1'b1;
                    else if (mx > 0) horiz_locked = 1'b1;
                end else if (cfg.vertical_enable) begin
                    if (my > 0) vert_locked = 1'b1;
                end else if (cfg.horizontal_enable) begin
                    if (mx > 0) horiz_locked = 1'b1;
                end
            end

            if (vert_locked || horiz_locked) begin
                res.gesture = GEST_DRAGGED;
                if (horiz_locked) res.drag_dx = 16'(sx);
                if (vert_locked) res.drag_dy = 16'(sy);
            end
        end else if (armed && ev.mode == MODE_RELEASE) begin
            armed = 1'b0;
            if (!vert_locked && !horiz_locked) res.gesture = GEST_TOUCHED;
        end
        return res;
    endfunction

    // Channel monitor: register writes, result comparison, then prediction.
    always @(posedge i_clk) begin
        t_event  ev;
        t_result exp_res;
        if (!i_rst_n) begin
            cfg.region_left       = '0;
            cfg.region_top        = '0;
            cfg.region_width      = 15'h7fff;
            cfg.region_height     = 15'h7fff;
            cfg.drag_threshold    = '0;
            cfg.vertical_enable   = 1'b1;
            cfg.horizontal_enable = 1'b1;
            cfg.multi_axis_enable = 1'b0;
            armed        = 1'b0;
            vert_locked  = 1'b0;
            horiz_locked = 1'b0;
            prev_x       = 0;
            prev_y       = 0;
            expected_gestures.delete();
        end else begin
            // Register write transaction.
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[4:2]))
                    REG_REGION_LEFT:   cfg.region_left       = i_pwdata[14:0];
                    REG_REGION_TOP:    cfg.region_top        = i_pwdata[14:0];
                    REG_REGION_WIDTH:  cfg.region_width      = i_pwdata[14:0];
                    REG_REGION_HEIGHT: cfg.region_height     = i_pwdata[14:0];
                    REG_DRAG_THRESH:   cfg.drag_threshold    = i_pwdata[14:0];
                    REG_VERT_EN:       cfg.vertical_enable   = i_pwdata[0];
                    REG_HORIZ_EN:      cfg.horizontal_enable = i_pwdata[0];
                    REG_MULTI_AXIS_EN: cfg.multi_axis_enable = i_pwdata[0];
                    default: ;
                endcase
            end

            // Result transaction against the oldest prediction.
            if (i_m_tvalid && i_m_tready) begin
                o_result_count++;
                if (i_m_tuser == GEST_DRAGGED) o_drag_count++;
                if (i_m_tuser == GEST_TOUCHED) o_touch_count++;
                if (expected_gestures.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result: expected none,", $time,
                             " actual gesture %0d dx %0d dy %0d",
                             i_m_tuser, $signed(i_m_tdata[15:0]),
                             $signed(i_m_tdata[31:16]));
                end else begin
                    exp_res = expected_gestures.pop_front();
                    if (i_m_tuser !== exp_res.gesture
                        || i_m_tdata[15:0] !== exp_res.drag_dx
                        || i_m_tdata[31:16] !== exp_res.drag_dy) begin
                        o_fail_count++;
                        $display("%0t: result mismatch: expected gesture %0d dx %0d dy %0d,",
                                 $time, exp_res.gesture, exp_res.drag_dx,
                                 exp_res.drag_dy,
                                 " actual gesture %0d dx %0d dy %0d",
                                 i_m_tuser, $signed(i_m_tdata[15:0]),
                                 $signed(i_m_tdata[31:16]));
                    end
                end
            end

            // Event transaction: predict its gesture.
            if (i_s_tvalid && i_s_tready) begin
                ev.mode    = t_mode'(i_s_tuser);
                ev.point_x = i_s_tdata[14:0];
                ev.point_y = i_s_tdata[29:15];
                expected_gestures.push_back(recognize_event(ev));
            end
        end
        o_pending = expected_gestures.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Testbench top for the touch tap and drag recognizer. Drives touch events and
// register writes, randomizes idling on both stream sides and reports the
// verdict from the failure and pending counts of the gesture checker.
// ============================================================================
module tb;
    import ttd_pkg::*;

    localparam int CoordMax = 32767;

    logic              i_clk    = 1'b0;
    logic              i_rst_n  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata  = '0;     // [14:0] point_x, [29:15] point_y
    logic [1:0]        s_tuser  = MODE_OTHER;  // [1:0] mode
    logic              m_tvalid;
    logic              m_tready = 1'b1;
    logic [31:0]       m_tdata;           // [15:0] drag_dx, [31:16] drag_dy
    logic [1:0]        m_tuser;           // [1:0] gesture
    logic              psel     = 1'b0;
    logic              penable  = 1'b0;
    logic              pwrite   = 1'b0;
    logic [AddrW-1:0]  paddr    = '0;
    logic [DataW-1:0]  pwdata   = '0;
    logic [DataW-1:0]  prdata;
    logic              pready;

    int fail_count;
    int pending;
    int result_count;
    int drag_count;
    int touch_count;

    int send_gap_pct  = 0;
    int recv_stall_pct = 0;
    int events_sent   = 0;
    int settings_used = 0;

    // Shadow of the rectangle and threshold, used to aim presses and size steps.
    int cur_left   = 0;
    int cur_top    = 0;
    int cur_width  = CoordMax;
    int cur_height = CoordMax;
    int cur_thr    = 0;

    touch_tap_drag_recognizer u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    ttd_gesture_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_tvalid     (s_tvalid),
        .i_s_tready     (s_tready),
        .i_s_tdata      (s_tdata),
        .i_s_tuser      (s_tuser),
        .i_m_tvalid     (m_tvalid),
        .i_m_tready     (m_tready),
        .i_m_tdata      (m_tdata),
        .i_m_tuser      (m_tuser),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_pready       (pready),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count),
        .o_drag_count   (drag_count),
        .o_touch_count  (touch_count)
    );

    // Clock, 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Receiver back-pressure.
    always @(negedge i_clk) begin
        m_tready = !(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
    end

    // Hard limit on run time.
    initial begin
        #5_000_000;
        $display("touch_tap_drag_recognizer verification failed");
        $finish;
    end

    function automatic int clamp_coord(input int v);
        if (v < 0) return 0;
        if (v > CoordMax) return CoordMax;
        return v;
    endfunction

    // Random coordinate inside [start, start + len), or anywhere if empty.
    function automatic int pick_inside(input int start, input int len);
        int hi;
        if (len == 0) return $urandom_range(0, CoordMax);
        hi = start + len - 1;
        if (hi > CoordMax) hi = CoordMax;
        return $urandom_range(start, hi);
    endfunction

    // Signed step, mostly close to the threshold so locks are borderline.
    function automatic int pick_step();
        int mag;
        int span;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: mag = $urandom_range(0, cur_thr + 2);
            6, 7, 8: begin
                span = 2 * cur_thr + 100;
                if (span > CoordMax) span = CoordMax;
                mag = $urandom_range(0, span);
            end
            default: mag = $urandom_range(0, CoordMax);
        endcase
        return $urandom_range(0, 1) ? -mag : mag;
    endfunction

    task automatic set_idling(input int pattern);
        case (pattern)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 73; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 73; end
            default: begin send_gap_pct = 35; recv_stall_pct = 35; end
        endcase
    endtask

    // Sends one event transaction; entered and left at a falling edge.
    task automatic send_event(input t_mode mode, input int x, input int y);
        while (send_gap_pct != 0 && $urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = mode;
        s_tdata  = {2'b00, y[14:0], x[14:0]};
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        if (mode != MODE_OTHER) events_sent++;
    endtask

    // Stops sending and waits for every predicted result to arrive.
    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apb_write(input t_reg_idx idx, input int value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic apply_config(input int left, input int top, input int width,
                                input int height, input int thr, input int v_en,
                                input int h_en, input int multi);
        drain();
        apb_write(REG_REGION_LEFT, left);
        apb_write(REG_REGION_TOP, top);
        apb_write(REG_REGION_WIDTH, width);
        apb_write(REG_REGION_HEIGHT, height);
        apb_write(REG_DRAG_THRESH, thr);
        apb_write(REG_VERT_EN, v_en);
        apb_write(REG_HORIZ_EN, h_en);
        apb_write(REG_MULTI_AXIS_EN, multi);
        cur_left   = left;
        cur_top    = top;
        cur_width  = width;
        cur_height = height;
        cur_thr    = thr;
        settings_used++;
    endtask

    // Random traffic: mostly press, moves, release; some noise and broken runs.
    task automatic run_random(input int count);
        int sent_here;
        int px;
        int py;
        int moves;
        logic held;
        sent_here = 0;
        held = 1'b0;
        while (sent_here < count) begin
            if (!held && sent_here >= count / 2) begin
                drain();
                held = 1'b1;
            end
            if ($urandom_range(0, 99) < 20) begin
                send_event(t_mode'($urandom_range(0, 3)), $urandom_range(0, CoordMax),
                           $urandom_range(0, CoordMax));
                sent_here++;
            end else begin
                if ($urandom_range(0, 9) == 0) begin
                    px = $urandom_range(0, CoordMax);
                    py = $urandom_range(0, CoordMax);
                end else begin
                    px = pick_inside(cur_left, cur_width);
                    py = pick_inside(cur_top, cur_height);
                end
                send_event(MODE_PRESS, px, py);
                sent_here++;
                moves = $urandom_range(0, 8);
                repeat (moves) begin
                    px = clamp_coord(px + pick_step());
                    py = clamp_coord(py + pick_step());
                    send_event(MODE_MOVE, px, py);
                    sent_here++;
                end
                if ($urandom_range(0, 9) != 0) begin
                    send_event(MODE_RELEASE, $urandom_range(0, CoordMax),
                               $urandom_range(0, CoordMax));
                    sent_here++;
                end
            end
        end
    endtask

    // Stimulus and verdict.
    initial begin
        int phase;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (2) @(negedge i_clk);

        // Directed events under the reset register values.
        set_idling(0);
        send_event(MODE_MOVE, 0, 0);                     // move while not armed
        send_event(MODE_RELEASE, CoordMax, CoordMax);    // release while not armed
        send_event(MODE_OTHER, CoordMax, 0);             // non-touch event
        send_event(MODE_PRESS, CoordMax, 5);             // just right of the rectangle
        send_event(MODE_PRESS, 0, 0);
        send_event(MODE_MOVE, CoordMax - 1, 0);          // positive x step of CoordMax - 1
        send_event(MODE_MOVE, 0, CoordMax - 1);          // negative x step of CoordMax - 1
        send_event(MODE_RELEASE, 0, 0);                  // release after a drag
        send_event(MODE_MOVE, 10, 10);
        send_event(MODE_PRESS, 100, 100);
        send_event(MODE_MOVE, 100, 200);                 // vertical wins
        send_event(MODE_RELEASE, 100, 200);
        send_event(MODE_PRESS, 10, 10);
        send_event(MODE_RELEASE, 10, 10);                // plain tap
        send_event(MODE_PRESS, 50, 50);
        send_event(MODE_MOVE, 60, 60);                   // tie goes horizontal
        send_event(MODE_RELEASE, 60, 60);

        // Multi-axis: one axis locks, then the other stays out until a press.
        apply_config(0, 0, CoordMax, CoordMax, 5, 1, 1, 1);
        send_event(MODE_PRESS, 1000, 1000);
        send_event(MODE_MOVE, 1010, 1003);
        send_event(MODE_MOVE, 1020, 1100);
        send_event(MODE_PRESS, 2000, 2000);
        send_event(MODE_MOVE, 1990, 2010);               // both axes lock
        send_event(MODE_RELEASE, 1990, 2010);

        // Empty rectangle takes no press.
        apply_config(0, 0, 0, CoordMax, 0, 1, 1, 0);
        send_event(MODE_PRESS, 0, 0);
        send_event(MODE_MOVE, 5, 5);

        // Random phases over a spread of register settings.
        for (phase = 0; phase < 10; phase++) begin
            case (phase)
                0: apply_config(0, 0, CoordMax, CoordMax, 0, 1, 1, 0);
                1: apply_config($urandom_range(0, 30000), $urandom_range(0, 30000),
                                $urandom_range(1, 2767), $urandom_range(1, 2767),
                                $urandom_range(0, 20), 1, 1, 1);
                2: apply_config(0, 0, CoordMax, CoordMax, CoordMax, 1, 1, 0);
                3: apply_config(0, 0, CoordMax, CoordMax, 8, 0, 1, 0);
                4: apply_config(0, 0, CoordMax, CoordMax, 8, 1, 0, 0);
                5: apply_config(0, 0, CoordMax, CoordMax, 3, 0, 0, 0);
                6: apply_config(CoordMax, CoordMax, 1, 1, 0, 1, 1, 1);
                7: apply_config($urandom_range(0, CoordMax), $urandom_range(0, CoordMax),
                                CoordMax, 0, 5, 1, 1, 1);
                8: apply_config(0, 0, CoordMax, CoordMax, $urandom_range(0, 500), 1, 1, 1);
                default: apply_config($urandom_range(0, 1000), $urandom_range(0, 1000),
                                      $urandom_range(1000, CoordMax),
                                      $urandom_range(1000, CoordMax),
                                      $urandom_range(0, 64), 0, 1, 1);
            endcase
            set_idling(phase % 4);
            run_random(175);
        end

        // Let the last results come out.
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);

        $display("Run covered %0d touch events and %0d results (%0d drags, %0d taps)",
                 events_sent, result_count, drag_count, touch_count);
        $display("over %0d register settings and four idling patterns.", settings_used);
        if (fail_count == 0 && pending == 0) begin
            $display("touch_tap_drag_recognizer verification clean");
        end else begin
            $display("touch_tap_drag_recognizer verification failed");
        end
        $finish;
    end

endmodule

// ===== touch_tap_drag_recognizer.f =====
hw/rtl/ttd_pkg.sv
hw/rtl/ttd_cfg.sv
hw/rtl/ttd_in_stage.sv
hw/rtl/ttd_gesture.sv
hw/rtl/ttd_out_stage.sv
hw/rtl/touch_tap_drag_recognizer.sv
hw/rtl/ttd_checker.sv
tb/ttd_gesture_checker.sv
tb/tb.sv
